// ===== rtl/core/crcrp_pkg.sv =====
// Shared types, codes and the byte-wide CRC-8 step of the framed response parser.
// No dependencies; the step logic, the top and the testbench import this package.
package crcrp_pkg;

    // Longest response frame accepted, header and CRC included.
    localparam int MAX_RESPONSE_LENGTH = 16;

    // Fixed frame layout constants.
    localparam int    INFO_LAST_POS = 4;
    localparam int    MIN_RESP_LEN  = 4;
    localparam int    ACK_LEN       = 6;
    localparam int    NAK_LEN       = 5;
    localparam int    INFO_LEN      = 5;
    localparam [7:0]  ACK_CODE      = 8'h01;
    localparam [7:0]  NAK_CODE      = 8'hFF;
    localparam [7:0]  CRC_POLY      = 8'hD5;

    // Configuration register indexes.
    localparam [0:0] REG_INFO_HEADER     = 1'b0;
    localparam [0:0] REG_RESPONSE_HEADER = 1'b1;
    localparam [7:0] INFO_HEADER_RST     = 8'hCC;
    localparam [7:0] RESPONSE_HEADER_RST = 8'h55;

    // Parser phases.
    localparam [2:0] PH_IDLE  = 3'd0;
    localparam [2:0] PH_INFO  = 3'd1;
    localparam [2:0] PH_RLEN  = 3'd2;
    localparam [2:0] PH_RBODY = 3'd3;
    localparam [2:0] PH_DONE  = 3'd4;

    // Result status codes.
    localparam [2:0] ST_OK         = 3'd0;
    localparam [2:0] ST_TIMEOUT    = 3'd1;
    localparam [2:0] ST_INCOMPLETE = 3'd2;
    localparam [2:0] ST_CRC        = 3'd3;
    localparam [2:0] ST_BADLEN     = 3'd4;
    localparam [2:0] ST_BADHDR     = 3'd5;

    // Result kind codes.
    localparam [1:0] KIND_INFO = 2'd0;
    localparam [1:0] KIND_ACK  = 2'd1;
    localparam [1:0] KIND_NAK  = 2'd2;

    // Control state of one receive window.
    typedef struct packed {
        logic [2:0] phase;
        logic [4:0] byte_count;
        logic [7:0] crc_accum;
        logic [4:0] expected_length;
    } parse_state_t;

    // One result item.
    typedef struct packed {
        logic [2:0]  status;
        logic [1:0]  kind;
        logic [7:0]  proto_version;
        logic [15:0] feature_mask;
        logic [7:0]  action_echo;
        logic [7:0]  error_code;
        logic [4:0]  frame_bytes;
    } result_t;

    // Write request into the captured byte store.
    typedef struct packed {
        logic       we;
        logic [1:0] idx;
    } cap_wr_t;

    // One byte through the CRC-8 register, MSB first.
    function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++)
        begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/crcrp_if.sv =====
// Handshake channel interfaces of the framed response parser: byte input,
// result output and configuration write. Depends on nothing.
interface crcrp_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] rx_byte;

    modport source (output valid, output func, output rx_byte, input ready);
    modport sink   (input valid, input func, input rx_byte, output ready);
endinterface

interface crcrp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [1:0]  kind;
    logic [7:0]  proto_version;
    logic [15:0] feature_mask;
    logic [7:0]  action_echo;
    logic [7:0]  error_code;
    logic [4:0]  frame_bytes;

    modport source (output valid, output status, output kind, output proto_version,
                    output feature_mask, output action_echo, output error_code,
                    output frame_bytes, input ready);
    modport sink   (input valid, input status, input kind, input proto_version,
                    input feature_mask, input action_echo, input error_code,
                    input frame_bytes, output ready);
endinterface

interface crcrp_cfg_if;
    logic       valid;
    logic       ready;
    logic [0:0] index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/crcrp_step.sv =====
// Next-state and result logic for one received byte or end-of-window item.
// Depends on crcrp_pkg.
module crcrp_step
    import crcrp_pkg::*;
(
    input  parse_state_t cur,
    input  logic [7:0]   cap0,
    input  logic [7:0]   cap1,
    input  logic [7:0]   cap2,
    input  logic [7:0]   cap3,
    input  logic         func,
    input  logic [7:0]   rx_byte,
    input  logic [7:0]   info_header,
    input  logic [7:0]   response_header,
    output parse_state_t nxt,
    output cap_wr_t      cap_wr,
    output logic         emit,
    output result_t      res
);

    logic [7:0] crc_upd;
    logic [4:0] pos;
    logic [5:0] pos_inc;

    assign crc_upd = crc8_next(cur.crc_accum, rx_byte);
    assign pos     = cur.byte_count;
    assign pos_inc = {1'b0, pos} + 6'd1;

    always_comb
    begin
        nxt        = cur;
        cap_wr.we  = 1'b0;
        cap_wr.idx = 2'(pos - 5'd1);
        emit       = 1'b0;
        res        = '0;

        if (func)
        begin
            // End of window always returns to idle.
            nxt = '0;
            nxt.phase = PH_IDLE;
            if (cur.phase == PH_IDLE)
            begin
                emit       = 1'b1;
                res.status = ST_TIMEOUT;
            end
            else if (cur.phase != PH_DONE)
            begin
                emit       = 1'b1;
                res.status = ST_INCOMPLETE;
            end
        end
        else if (cur.phase != PH_DONE)
        begin
            cap_wr.we = (pos >= 5'd1) && (pos <= 5'd4);
            case (cur.phase)
                PH_IDLE:
                begin
                    nxt.crc_accum  = crc8_next(8'h00, rx_byte);
                    nxt.byte_count = 5'd1;
                    if (rx_byte == info_header)
                        nxt.phase = PH_INFO;
                    else if (rx_byte == response_header)
                        nxt.phase = PH_RLEN;
                    else
                    begin
                        nxt.phase  = PH_DONE;
                        emit       = 1'b1;
                        res.status = ST_BADHDR;
                    end
                end
                PH_INFO:
                begin
                    if (pos < 5'(INFO_LAST_POS))
                    begin
                        nxt.crc_accum  = crc_upd;
                        nxt.byte_count = pos_inc[4:0];
                    end
                    else
                    begin
                        nxt.phase = PH_DONE;
                        emit      = 1'b1;
                        if (cur.crc_accum != rx_byte)
                            res.status = ST_CRC;
                        else
                        begin
                            res.status        = ST_OK;
                            res.kind          = KIND_INFO;
                            res.proto_version = cap0;
                            res.feature_mask  = {cap2, cap1};
                            res.frame_bytes   = 5'(INFO_LEN);
                        end
                    end
                end
                PH_RLEN:
                begin
                    nxt.crc_accum  = crc_upd;
                    nxt.byte_count = 5'd2;
                    if ((rx_byte < 8'(MIN_RESP_LEN)) || (rx_byte > 8'(MAX_RESPONSE_LENGTH)))
                    begin
                        nxt.phase  = PH_DONE;
                        emit       = 1'b1;
                        res.status = ST_BADLEN;
                    end
                    else
                    begin
                        nxt.expected_length = rx_byte[4:0];
                        nxt.phase           = PH_RBODY;
                    end
                end
                PH_RBODY:
                begin
                    if (pos_inc < {1'b0, cur.expected_length})
                    begin
                        nxt.crc_accum  = crc_upd;
                        nxt.byte_count = pos_inc[4:0];
                    end
                    else
                    begin
                        nxt.phase = PH_DONE;
                        emit      = 1'b1;
                        if (cur.crc_accum != rx_byte)
                            res.status = ST_CRC;
                        else if ((cap1 == ACK_CODE) && (cur.expected_length == 5'(ACK_LEN)))
                        begin
                            res.status      = ST_OK;
                            res.kind        = KIND_ACK;
                            res.action_echo = cap3;
                            res.frame_bytes = 5'(ACK_LEN);
                        end
                        else if ((cap1 == NAK_CODE) && (cur.expected_length == 5'(NAK_LEN)))
                        begin
                            res.status      = ST_OK;
                            res.kind        = KIND_NAK;
                            res.error_code  = cap2;
                            res.frame_bytes = 5'(NAK_LEN);
                        end
                        else
                            res.status = ST_BADLEN;
                    end
                end
                default:
                begin
                    cap_wr.we = 1'b0;
                    nxt.phase = PH_DONE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/core/crc8_response_frame_parser_top.sv =====
// Top level of the CRC-8 framed response parser: input register, parse logic,
// result register. Depends on crcrp_pkg, crcrp_if.sv and crcrp_step.
//
// The parser takes one request per clock cycle on the rx channel: each request is
// either a received byte or an end-of-window marker. A received request is first
// held in an input register; from there the byte-wide CRC-8 (polynomial 0xD5,
// initial value zero) and the frame state machine process it in a single pass
// and, when the byte decides the frame, load the result register. A result is
// offered on the result channel from the result register once its deciding request
// has passed the input register, and the sustained rate is one request per cycle
// unless a waiting result holds the flow. The rx channel keeps accepting while
// a result waits on the result channel, and stalls only when both the input and
// the result register are full. Each receive window yields exactly one result: a
// decoded device info, acknowledge or reject frame, or an error status (timeout for
// an empty window, incomplete for a short one, CRC error, bad length, bad header).
// Bytes that arrive after the decision are dropped until the end marker. The two
// header registers may only be written while no request is in flight; writes are
// always accepted.
module crc8_response_frame_parser_top
    import crcrp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    crcrp_in_if.sink     rx,
    crcrp_out_if.source  result,
    crcrp_cfg_if.sink    cfg
);

    // Header configuration registers.
    logic [7:0] info_header_reg;
    logic [7:0] response_header_reg;

    // Input register stage.
    logic       in_valid_reg;
    logic       in_func_reg;
    logic [7:0] in_byte_reg;

    // Window state and captured frame bytes 1 to 4.
    parse_state_t state_reg;
    parse_state_t state_next;
    logic [7:0]   cap_reg [4];
    cap_wr_t      cap_wr;

    // Result register stage.
    logic    out_valid_reg;
    result_t out_reg;
    result_t out_next;
    logic    emit;

    logic rx_fire;
    logic proc_fire;

    // The parse stage advances whenever the result register is free or draining.
    assign proc_fire = in_valid_reg && (!out_valid_reg || result.ready);
    assign rx.ready  = !in_valid_reg || proc_fire;
    assign rx_fire   = rx.valid && rx.ready;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            info_header_reg     <= INFO_HEADER_RST;
            response_header_reg <= RESPONSE_HEADER_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_INFO_HEADER:     info_header_reg     <= cfg.data;
                REG_RESPONSE_HEADER: response_header_reg <= cfg.data;
                default:             info_header_reg     <= info_header_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (rx_fire)
            in_valid_reg <= 1'b1;
        else if (proc_fire)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (rx_fire)
        begin
            in_func_reg <= rx.func;
            in_byte_reg <= rx.rx_byte;
        end
    end

    crcrp_step u_step (
        .cur             (state_reg),
        .cap0            (cap_reg[0]),
        .cap1            (cap_reg[1]),
        .cap2            (cap_reg[2]),
        .cap3            (cap_reg[3]),
        .func            (in_func_reg),
        .rx_byte         (in_byte_reg),
        .info_header     (info_header_reg),
        .response_header (response_header_reg),
        .nxt             (state_next),
        .cap_wr          (cap_wr),
        .emit            (emit),
        .res             (out_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '{phase: PH_IDLE, byte_count: 5'd0, crc_accum: 8'h00,
                           expected_length: 5'd0};
        else if (proc_fire)
            state_reg <= state_next;
    end

    // Captured bytes are only read after being written in the same window.
    always_ff @(posedge clk)
    begin
        if (proc_fire && cap_wr.we)
            cap_reg[cap_wr.idx] <= in_byte_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (proc_fire)
            out_valid_reg <= emit;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (proc_fire && emit)
            out_reg <= out_next;
    end

    assign result.valid         = out_valid_reg;
    assign result.status        = out_reg.status;
    assign result.kind          = out_reg.kind;
    assign result.proto_version = out_reg.proto_version;
    assign result.feature_mask  = out_reg.feature_mask;
    assign result.action_echo   = out_reg.action_echo;
    assign result.error_code    = out_reg.error_code;
    assign result.frame_bytes   = out_reg.frame_bytes;

`ifndef SYNTHESIS
    // An end-of-window request always leaves the parser idle and cleared.
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (proc_fire && in_func_reg) |=>
            (state_reg.phase == PH_IDLE && state_reg.byte_count == 5'd0
             && state_reg.crc_accum == 8'h00))
        else $error("end of window did not clear the parser state");

    // While collecting a device info frame the byte position stays within the frame.
    a_info_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.phase == PH_INFO) |->
            (state_reg.byte_count >= 5'd1 && state_reg.byte_count <= 5'(INFO_LAST_POS)))
        else $error("device info byte position out of range");

    // A new result only appears after the parse stage has processed a request.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(proc_fire))
        else $error("result appeared without a processed request");
`endif

endmodule

// ===== dv/crc8_response_frame_parser_top_tb.sv =====
// Self-checking testbench of the CRC-8 framed response parser, driving the rx and
// header register channels and checking every result against its own frame model.
// Depends on crcrp_pkg, the channel interfaces in crcrp_if.sv and the parser top.
`timescale 1ns / 100ps

module crc8_response_frame_parser_top_tb;
    import crcrp_pkg::*;

    typedef logic [7:0] byte_q_t[$];

    // Cycles allowed after the last outstanding result before the block counts as idle:
    // a request that decides nothing may still sit in the input register.
    localparam int SETTLE_CYCLES   = 8;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int PHASE_REQUESTS  = 300;
    localparam int LONG_HOLD       = 250;
    localparam int MAX_GAP         = 19;
    localparam int REPORT_LIMIT    = 10;

    logic clk;
    logic rst_n;

    crcrp_in_if  rx_ch ();
    crcrp_out_if res_ch ();
    crcrp_cfg_if cfg_ch ();

    crc8_response_frame_parser_top u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .rx     (rx_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    // Model of one receive window: the testbench's own view of the parser state,
    // plus its copy of the two header registers.
    logic [2:0] fr_phase;
    logic [4:0] fr_count;
    logic [7:0] fr_crc;
    logic [4:0] fr_len;
    logic [7:0] fr_cap [4];
    logic [7:0] hdr_info;
    logic [7:0] hdr_resp;

    // Decoded frames still owed by the block, oldest first.
    result_t frame_outcomes[$];

    // Run bookkeeping.
    int cycle_count;
    int fault_count;
    int live_requests;
    int ignored_requests;
    int window_count;
    int result_count;
    int cfg_writes;
    int status_seen [8];

    // Idling controls for the sender and the receiver.
    bit rx_gaps_on;
    bit res_stalls_on;
    int hold_off_cycles;

    // CRC-8 with polynomial 0xD5, shifted in one bit at a time, MSB first.
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        logic fb;
        c = crc;
        for (int i = 7; i >= 0; i--)
        begin
            fb = c[7] ^ b[i];
            c  = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
        end
        return c;
    endfunction

    function automatic logic [7:0] crc_over(input byte_q_t q);
        logic [7:0] c;
        c = 8'h00;
        foreach (q[i])
            c = crc8_step(c, q[i]);
        return c;
    endfunction

    // Applies one accepted request to the window model. Returns 1 when the request
    // decides the window, with the decoded frame in r.
    function automatic bit decode_window_byte(input bit is_end, input logic [7:0] b,
                                              output result_t r);
        logic [2:0] prior;
        int pos;
        r = '0;
        if (is_end)
        begin
            prior    = fr_phase;
            fr_phase = PH_IDLE;
            fr_count = '0;
            fr_crc   = '0;
            fr_len   = '0;
            if (prior == PH_DONE)
                return 1'b0;
            r.status = (prior == PH_IDLE) ? ST_TIMEOUT : ST_INCOMPLETE;
            return 1'b1;
        end
        if (fr_phase == PH_DONE)
            return 1'b0;

        pos = fr_count;
        if (pos >= 1 && pos <= 4)
            fr_cap[pos - 1] = b;

        case (fr_phase)
            PH_IDLE:
            begin
                fr_crc   = crc8_step(8'h00, b);
                fr_count = 5'd1;
                // The info header wins when both registers hold the same value.
                if (b == hdr_info)
                begin
                    fr_phase = PH_INFO;
                    return 1'b0;
                end
                if (b == hdr_resp)
                begin
                    fr_phase = PH_RLEN;
                    return 1'b0;
                end
                fr_phase = PH_DONE;
                r.status = ST_BADHDR;
                return 1'b1;
            end
            PH_INFO:
            begin
                if (pos < INFO_LAST_POS)
                begin
                    fr_crc   = crc8_step(fr_crc, b);
                    fr_count = 5'(pos + 1);
                    return 1'b0;
                end
                fr_phase = PH_DONE;
                if (fr_crc != b)
                begin
                    r.status = ST_CRC;
                    return 1'b1;
                end
                r.status        = ST_OK;
                r.kind          = KIND_INFO;
                r.proto_version = fr_cap[0];
                r.feature_mask  = {fr_cap[2], fr_cap[1]};
                r.frame_bytes   = 5'(INFO_LEN);
                return 1'b1;
            end
            PH_RLEN:
            begin
                fr_crc   = crc8_step(fr_crc, b);
                fr_count = 5'd2;
                if (b < MIN_RESP_LEN || b > MAX_RESPONSE_LENGTH)
                begin
                    fr_phase = PH_DONE;
                    r.status = ST_BADLEN;
                    return 1'b1;
                end
                fr_len   = b[4:0];
                fr_phase = PH_RBODY;
                return 1'b0;
            end
            PH_RBODY:
            begin
                if (pos + 1 < fr_len)
                begin
                    fr_crc   = crc8_step(fr_crc, b);
                    fr_count = 5'(pos + 1);
                    return 1'b0;
                end
                fr_phase = PH_DONE;
                if (fr_crc != b)
                    r.status = ST_CRC;
                else if (fr_cap[1] == ACK_CODE && fr_len == ACK_LEN)
                begin
                    r.status      = ST_OK;
                    r.kind        = KIND_ACK;
                    r.action_echo = fr_cap[3];
                    r.frame_bytes = 5'(ACK_LEN);
                end
                else if (fr_cap[1] == NAK_CODE && fr_len == NAK_LEN)
                begin
                    r.status      = ST_OK;
                    r.kind        = KIND_NAK;
                    r.error_code  = fr_cap[2];
                    r.frame_bytes = 5'(NAK_LEN);
                end
                else
                    r.status = ST_BADLEN;
                return 1'b1;
            end
            default:
            begin
                fr_phase = PH_DONE;
                return 1'b0;
            end
        endcase
    endfunction

    // Device info frame under the current info header; crc_ok = 0 spoils the CRC byte.
    function automatic byte_q_t info_frame(input logic [7:0] ver, input logic [15:0] mask,
                                           input bit crc_ok);
        byte_q_t q;
        logic [7:0] c;
        q = {hdr_info, ver, mask[7:0], mask[15:8]};
        c = crc_over(q);
        q.push_back(crc_ok ? c : c ^ 8'($urandom_range(1, 255)));
        return q;
    endfunction

    // Response frame: header, length byte, status byte, random payload, CRC. A length
    // byte out of range still gets a short body; the parser drops it after deciding.
    function automatic byte_q_t response_frame(input logic [7:0] len_byte,
                                               input logic [7:0] code, input bit crc_ok);
        byte_q_t q;
        logic [7:0] c;
        int total;
        if (len_byte >= MIN_RESP_LEN && len_byte <= MAX_RESPONSE_LENGTH)
            total = len_byte;
        else
            total = $urandom_range(MIN_RESP_LEN, 8);
        q = {hdr_resp, len_byte, code};
        while (q.size() < total - 1)
            q.push_back(8'($urandom));
        c = crc_over(q);
        q.push_back(crc_ok ? c : c ^ 8'($urandom_range(1, 255)));
        return q;
    endfunction

    // Sends one request on the rx channel after a random gap, then records what the
    // parser owes for it. valid stays high when the next request follows at once.
    task automatic send_request(input bit is_end, input logic [7:0] b);
        int gap;
        result_t r;
        gap = rx_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0)
        begin
            rx_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.func    <= is_end;
        rx_ch.rx_byte <= b;
        do
            @(posedge clk);
        while (!rx_ch.ready);
        if (!is_end && fr_phase == PH_DONE)
            ignored_requests++;
        else
            live_requests++;
        if (decode_window_byte(is_end, b, r))
            frame_outcomes.push_back(r);
    endtask

    // One receive window: the given bytes, then the end marker with a random byte
    // on the ignored data lines.
    task automatic send_window(input byte_q_t q);
        foreach (q[i])
            send_request(1'b0, q[i]);
        send_request(1'b1, 8'($urandom));
        window_count++;
    endtask

    // Stops offering requests and waits until every owed result has been taken.
    task automatic wait_results_drained();
        rx_ch.valid <= 1'b0;
        while (frame_outcomes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Header registers change only with the parser idle.
    task automatic write_header_reg(input logic [0:0] idx, input logic [7:0] value);
        wait_results_drained();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        if (idx == REG_INFO_HEADER)
            hdr_info = value;
        else
            hdr_resp = value;
        cfg_writes++;
    endtask

    // Empty window, good frames of every kind (the info frames at the byte extremes),
    // and bytes that trail a decided frame.
    task automatic test_good_frames();
        byte_q_t q;
        q = {};
        send_window(q);
        send_window(info_frame(8'h00, 16'hFFFF, 1'b1));
        send_window(info_frame(8'hFF, 16'h0000, 1'b1));
        send_window(response_frame(8'(ACK_LEN), ACK_CODE, 1'b1));
        q = response_frame(8'(NAK_LEN), NAK_CODE, 1'b1);
        q.push_back(8'($urandom));
        send_window(q);
    endtask

    // Unknown header, lengths just outside the legal range, a short window, a bad
    // CRC, and a good CRC on a status byte that does not match its length.
    task automatic test_error_frames();
        send_window({8'hFF});
        send_window({hdr_resp, 8'(MIN_RESP_LEN - 1)});
        send_window({hdr_resp, 8'(MAX_RESPONSE_LENGTH + 1)});
        send_window({hdr_info, 8'h12});
        send_window(info_frame(8'($urandom), 16'($urandom), 1'b0));
        send_window(response_frame(8'(ACK_LEN), NAK_CODE, 1'b1));
    endtask

    // Header registers at their extremes, then both equal so the info frame wins.
    task automatic test_header_registers();
        write_header_reg(REG_INFO_HEADER, 8'h00);
        write_header_reg(REG_RESPONSE_HEADER, 8'hFF);
        send_window(info_frame(8'($urandom), 16'($urandom), 1'b1));
        send_window(response_frame(8'(NAK_LEN), NAK_CODE, 1'b1));
        send_window({INFO_HEADER_RST});
        write_header_reg(REG_INFO_HEADER, 8'h5A);
        write_header_reg(REG_RESPONSE_HEADER, 8'h5A);
        send_window(info_frame(8'($urandom), 16'($urandom), 1'b1));
        write_header_reg(REG_INFO_HEADER, INFO_HEADER_RST);
        write_header_reg(REG_RESPONSE_HEADER, RESPONSE_HEADER_RST);
    endtask

    // The receiver holds off for a long stretch while empty windows arrive back to
    // back, so the input side must stall; after all results drain, info frames follow.
    task automatic test_backpressure();
        rx_gaps_on      = 1'b0;
        res_stalls_on   = 1'b0;
        hold_off_cycles = LONG_HOLD;
        repeat (40)
            send_request(1'b1, 8'($urandom));
        wait_results_drained();
        res_stalls_on = 1'b1;
        repeat (6)
            send_window(info_frame(8'($urandom), 16'($urandom), 1'b1));
        wait_results_drained();
        rx_gaps_on = 1'b1;
    endtask

    // One random window. Most are well-formed frames with random content; the rest
    // are cut short, carry trailing bytes, or are plain noise.
    task automatic run_random_window();
        byte_q_t q;
        int pick;
        int sel;
        int cut;
        logic [7:0] len_byte;
        logic [7:0] code;
        pick = $urandom_range(0, 99);
        if (pick < 5)
            q = {};
        else if (pick < 37)
            q = info_frame(8'($urandom), 16'($urandom), $urandom_range(0, 9) != 0);
        else if (pick < 80)
        begin
            sel = $urandom_range(0, 9);
            if (sel < 4)
                len_byte = 8'(ACK_LEN);
            else if (sel < 7)
                len_byte = 8'(NAK_LEN);
            else if (sel < 9)
                len_byte = 8'($urandom_range(MIN_RESP_LEN, MAX_RESPONSE_LENGTH));
            else
                len_byte = 8'($urandom);
            sel = $urandom_range(0, 4);
            if (sel < 2)
                code = (len_byte == NAK_LEN) ? NAK_CODE : ACK_CODE;
            else if (sel < 4)
                code = (sel == 2) ? ACK_CODE : NAK_CODE;
            else
                code = 8'($urandom);
            q = response_frame(len_byte, code, $urandom_range(0, 9) != 0);
        end
        else
        begin
            q = {};
            sel = $urandom_range(0, 2);
            if (sel == 0)
                q.push_back(hdr_info);
            else if (sel == 1)
                q.push_back(hdr_resp);
            repeat ($urandom_range(1, 12))
                q.push_back(8'($urandom));
        end

        // Cut a window short so the end marker arrives mid-frame.
        if (q.size() > 1 && $urandom_range(0, 99) < 12)
        begin
            cut = $urandom_range(1, q.size() - 1);
            while (q.size() > cut)
                void'(q.pop_back());
        end
        if (q.size() > 0 && $urandom_range(0, 99) < 15)
            repeat ($urandom_range(1, 3))
                q.push_back(8'($urandom));
        send_window(q);
    endtask

    // Four header settings; each runs until its share of requests has gone in,
    // switching between idling and back-to-back stretches on both sides.
    task automatic test_random_windows();
        int goal;
        int mode;
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    write_header_reg(REG_INFO_HEADER, INFO_HEADER_RST);
                    write_header_reg(REG_RESPONSE_HEADER, RESPONSE_HEADER_RST);
                end
                2:
                begin
                    write_header_reg(REG_INFO_HEADER, 8'hFF);
                    write_header_reg(REG_RESPONSE_HEADER, 8'h00);
                end
                default:
                begin
                    write_header_reg(REG_INFO_HEADER, 8'($urandom));
                    write_header_reg(REG_RESPONSE_HEADER, 8'($urandom));
                end
            endcase
            goal = live_requests + ignored_requests + PHASE_REQUESTS;
            while (live_requests + ignored_requests < goal)
            begin
                if ($urandom_range(0, 11) == 0)
                begin
                    mode          = $urandom_range(0, 3);
                    rx_gaps_on    = mode[0];
                    res_stalls_on = mode[1];
                end
                run_random_window();
            end
        end
        rx_gaps_on    = 1'b1;
        res_stalls_on = 1'b1;
    endtask

    // 10 ns clock.
    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    // Cycle counter and run limit: a stuck handshake ends the run as a failure.
    initial
        cycle_count = 0;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Run limit of %0d cycles reached with %0d results owed",
                     CYCLE_LIMIT, frame_outcomes.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Result receiver: waits a random number of cycles before taking each result,
    // and honors a long hold-off when the backpressure test asks for one.
    initial
    begin : result_receiver
        int stall;
        res_ch.ready = 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_off_cycles > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (hold_off_cycles) @(posedge clk);
                hold_off_cycles = 0;
            end
            stall = res_stalls_on ? $urandom_range(0, MAX_GAP) : 0;
            if (stall > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!res_ch.valid);
        end
    end

    // Result checker: each accepted result is matched with the oldest owed frame.
    always @(posedge clk)
    begin : result_checker
        result_t got;
        result_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got = {res_ch.status, res_ch.kind, res_ch.proto_version, res_ch.feature_mask,
                   res_ch.action_echo, res_ch.error_code, res_ch.frame_bytes};
            result_count++;
            status_seen[got.status]++;
            if (frame_outcomes.size() == 0)
            begin
                fault_count++;
                if (fault_count <= REPORT_LIMIT)
                    $display("Cycle %0d: result with none owed, status %0d kind %0d",
                             cycle_count, got.status, got.kind);
            end
            else
            begin
                want = frame_outcomes.pop_front();
                if (got.status !== want.status || got.kind !== want.kind ||
                    got.proto_version !== want.proto_version ||
                    got.feature_mask !== want.feature_mask ||
                    got.action_echo !== want.action_echo ||
                    got.error_code !== want.error_code ||
                    got.frame_bytes !== want.frame_bytes)
                begin
                    fault_count++;
                    if (fault_count <= REPORT_LIMIT)
                    begin
                        $display("Cycle %0d: result mismatch (expected / actual)",
                                 cycle_count);
                        $display("  status %0d / %0d  kind %0d / %0d  version %02h / %02h",
                                 want.status, got.status, want.kind, got.kind,
                                 want.proto_version, got.proto_version);
                        $display("  mask %04h / %04h  action %02h / %02h  code %02h / %02h",
                                 want.feature_mask, got.feature_mask, want.action_echo,
                                 got.action_echo, want.error_code, got.error_code);
                        $display("  frame bytes %0d / %0d", want.frame_bytes,
                                 got.frame_bytes);
                    end
                end
            end
        end
    end

    // Main sequence: reset once, the directed tests, backpressure, then the random
    // windows under several header settings, and finally the verdict.
    initial
    begin
        rst_n           = 1'b0;
        rx_ch.valid     = 1'b0;
        rx_ch.func      = 1'b0;
        rx_ch.rx_byte   = 8'h00;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = REG_INFO_HEADER;
        cfg_ch.data     = 8'h00;
        hdr_info        = INFO_HEADER_RST;
        hdr_resp        = RESPONSE_HEADER_RST;
        fr_phase        = PH_IDLE;
        fr_count        = '0;
        fr_crc          = '0;
        fr_len          = '0;
        fr_cap          = '{default: 8'h00};
        fault_count     = 0;
        live_requests   = 0;
        ignored_requests = 0;
        window_count    = 0;
        result_count    = 0;
        cfg_writes      = 0;
        status_seen     = '{default: 0};
        rx_gaps_on      = 1'b1;
        res_stalls_on   = 1'b1;
        hold_off_cycles = 0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_good_frames();
        test_error_frames();
        test_header_registers();
        test_backpressure();
        test_random_windows();
        wait_results_drained();

        $display("Covered %0d windows, %0d live and %0d ignored requests, %0d header writes",
                 window_count, live_requests, ignored_requests, cfg_writes);
        $display("Results %0d: ok %0d, timeout %0d, short %0d, crc %0d, len %0d, hdr %0d",
                 result_count, status_seen[ST_OK], status_seen[ST_TIMEOUT],
                 status_seen[ST_INCOMPLETE], status_seen[ST_CRC], status_seen[ST_BADLEN],
                 status_seen[ST_BADHDR]);
        if (fault_count == 0 && frame_outcomes.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== crc8_response_frame_parser_top.f =====
rtl/core/crcrp_pkg.sv
rtl/core/crcrp_if.sv
rtl/core/crcrp_step.sv
rtl/core/crc8_response_frame_parser_top.sv
dv/crc8_response_frame_parser_top_tb.sv
